// ===== src/cssp_pkg.sv =====
// ----------------------------------------------------------------------------
// cssp_pkg
// Shared types and constants for the convex shape support point block.
// ----------------------------------------------------------------------------
package cssp_pkg;

    localparam int OUT_W = 18;
    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        KIND_SPHERE   = 2'd0,
        KIND_BOX      = 2'd1,
        KIND_CYLINDER = 2'd2,
        KIND_CAPSULE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_SHAPE_KIND  = 3'd0,
        REG_RADIUS      = 3'd1,
        REG_AXIS_LENGTH = 3'd2,
        REG_BOX_X       = 3'd3,
        REG_BOX_Y       = 3'd4,
        REG_BOX_Z       = 3'd5
    } t_reg_idx;

    // Per-item flags that travel next to the square root pipeline.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic pos_z;
        logic zero_xyz;
        logic zero_xy;
    } t_side;

endpackage

// ===== src/cssp_scale.sv =====
// ----------------------------------------------------------------------------
// cssp_scale
// Pipelined quotient r*a/sqrt(s), truncated: one result bit per stage,
// using running products so that the bit stages need no wide multiplier.
// ----------------------------------------------------------------------------
module cssp_scale
    import cssp_pkg::*;
#(
    parameter int DIM_WIDTH = 16,
    parameter int DIR_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [DIM_WIDTH-1:0]   i_radius,
    input  logic [DIR_WIDTH-1:0]   i_mag,
    input  logic [2*DIR_WIDTH-1:0] i_norm,
    output logic [DIM_WIDTH-1:0]   o_quot
);

    localparam int RAW = DIM_WIDTH + DIR_WIDTH;
    localparam int RR  = 2 * RAW;
    localparam int SW  = 2 * DIR_WIDTH;
    localparam int PW  = 2 * DIM_WIDTH + 2 * DIR_WIDTH + 2;

    logic [RAW-1:0] r_ra;
    logic [SW-1:0]  r_sa;
    logic [RR-1:0]  n_rr;

    logic [PW-1:0]        r_t [0:DIM_WIDTH-1];
    logic [SW-1:0]        r_s [0:DIM_WIDTH-1];
    logic [PW-1:0]        r_p [0:DIM_WIDTH-1];
    logic [PW-1:0]        r_qs[0:DIM_WIDTH-1];
    logic [DIM_WIDTH-1:0] r_q [0:DIM_WIDTH];

    logic [PW-1:0] n_cand [0:DIM_WIDTH-1];
    logic          n_take [0:DIM_WIDTH-1];

    assign n_rr = RR'(r_ra) * RR'(r_ra);

    // Stage k decides bit b. P holds q*q*s and QS holds q*s, so the square
    // of the candidate q | 2^b times s is P + QS*2^(b+1) + s*2^(2b).
    always_comb begin
        for (int k = 0; k < DIM_WIDTH; k++) begin
            n_cand[k] = r_p[k] + (r_qs[k] << (DIM_WIDTH - k))
                      + (PW'(r_s[k]) << (2 * (DIM_WIDTH - 1 - k)));
            n_take[k] = (n_cand[k] <= r_t[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ra    <= RAW'(i_radius) * RAW'(i_mag);
            r_sa    <= i_norm;
            r_t[0]  <= PW'(n_rr);
            r_s[0]  <= r_sa;
            r_p[0]  <= '0;
            r_qs[0] <= '0;
            r_q[0]  <= '0;
            for (int k = 0; k < DIM_WIDTH - 1; k++) begin
                r_t[k+1]  <= r_t[k];
                r_s[k+1]  <= r_s[k];
                r_p[k+1]  <= n_take[k] ? n_cand[k] : r_p[k];
                r_qs[k+1] <= n_take[k] ? (r_qs[k] + (PW'(r_s[k]) << (DIM_WIDTH - 1 - k)))
                                       : r_qs[k];
            end
            for (int k = 0; k < DIM_WIDTH; k++) begin
                r_q[k+1] <= n_take[k] ? (r_q[k] | (DIM_WIDTH'(1) << (DIM_WIDTH - 1 - k)))
                                      : r_q[k];
            end
        end
    end

    assign o_quot = r_q[DIM_WIDTH];

endmodule

// ===== src/convex_shape_support_point.sv =====
// Throughput: one transaction per cycle while the output is not stalled.
// The bit-per-stage root search sets the depth.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset is synchronous and active low; it clears valid bits and the registers.
// ----------------------------------------------------------------------------
// convex_shape_support_point
// Support point of a centered sphere, box, cylinder or capsule for a query
// direction, with an APB-style register port.
// ----------------------------------------------------------------------------
module convex_shape_support_point
    import cssp_pkg::*;
#(
    parameter int DIR_WIDTH = 16,
    parameter int DIM_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [DIR_WIDTH-1:0] i_dir_x,
    input  logic [DIR_WIDTH-1:0] i_dir_y,
    input  logic [DIR_WIDTH-1:0] i_dir_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_support_x,
    output logic [OUT_W-1:0]     o_support_y,
    output logic [OUT_W-1:0]     o_support_z
);

    localparam int LAT = DIM_WIDTH + 2;
    localparam int SW  = 2 * DIR_WIDTH;
    localparam int EW  = ((DIM_WIDTH > OUT_W) ? DIM_WIDTH : OUT_W) + 2;

    // ---------------- registers ----------------
    t_kind                r_kind;
    logic [DIM_WIDTH-1:0] r_radius, r_axis, r_box_x, r_box_y, r_box_z;
    logic                 n_wr;
    t_reg_idx             n_idx;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite;
    assign n_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_SPHERE;
            r_radius <= '0;
            r_axis   <= '0;
            r_box_x  <= '0;
            r_box_y  <= '0;
            r_box_z  <= '0;
        end else if (n_wr) begin
            case (n_idx)
                REG_SHAPE_KIND:  r_kind   <= t_kind'(pwdata[1:0]);
                REG_RADIUS:      r_radius <= pwdata[DIM_WIDTH-1:0];
                REG_AXIS_LENGTH: r_axis   <= pwdata[DIM_WIDTH-1:0];
                REG_BOX_X:       r_box_x  <= pwdata[DIM_WIDTH-1:0];
                REG_BOX_Y:       r_box_y  <= pwdata[DIM_WIDTH-1:0];
                REG_BOX_Z:       r_box_z  <= pwdata[DIM_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            REG_SHAPE_KIND:  prdata = 32'(r_kind);
            REG_RADIUS:      prdata = 32'(r_radius);
            REG_AXIS_LENGTH: prdata = 32'(r_axis);
            REG_BOX_X:       prdata = 32'(r_box_x);
            REG_BOX_Y:       prdata = 32'(r_box_y);
            REG_BOX_Z:       prdata = 32'(r_box_z);
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    logic r_ovalid;
    logic n_en;
    assign n_en    = !r_ovalid || !i_stall;
    assign o_stall = !n_en;

    logic                 r_v1;
    logic [DIR_WIDTH-1:0] r_ax, r_ay, r_az;
    logic [SW-1:0]        r_sqx, r_sqy, r_sqz;
    t_side                r_sb1;
    logic [DIR_WIDTH-1:0] n_ax, n_ay, n_az;

    assign n_ax = i_dir_x[DIR_WIDTH-1] ? DIR_WIDTH'(-i_dir_x) : i_dir_x;
    assign n_ay = i_dir_y[DIR_WIDTH-1] ? DIR_WIDTH'(-i_dir_y) : i_dir_y;
    assign n_az = i_dir_z[DIR_WIDTH-1] ? DIR_WIDTH'(-i_dir_z) : i_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (n_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ax           <= n_ax;
            r_ay           <= n_ay;
            r_az           <= n_az;
            r_sqx          <= SW'(n_ax) * SW'(n_ax);
            r_sqy          <= SW'(n_ay) * SW'(n_ay);
            r_sqz          <= SW'(n_az) * SW'(n_az);
            r_sb1.neg_x    <= i_dir_x[DIR_WIDTH-1];
            r_sb1.neg_y    <= i_dir_y[DIR_WIDTH-1];
            r_sb1.neg_z    <= i_dir_z[DIR_WIDTH-1];
            r_sb1.pos_z    <= !i_dir_z[DIR_WIDTH-1] && (i_dir_z != '0);
            r_sb1.zero_xy  <= (i_dir_x == '0) && (i_dir_y == '0);
            r_sb1.zero_xyz <= (i_dir_x == '0) && (i_dir_y == '0) && (i_dir_z == '0);
        end
    end

    // Cylinder normalizes by the XY length only.
    logic [SW-1:0] n_norm;
    assign n_norm = (r_kind == KIND_CYLINDER) ? (r_sqx + r_sqy) : (r_sqx + r_sqy + r_sqz);

    logic [DIM_WIDTH-1:0] n_qx, n_qy, n_qz;

    cssp_scale #(.DIM_WIDTH(DIM_WIDTH), .DIR_WIDTH(DIR_WIDTH)) u_scale_x (
        .i_clk(i_clk), .i_en(n_en), .i_radius(r_radius), .i_mag(r_ax),
        .i_norm(n_norm), .o_quot(n_qx)
    );
    cssp_scale #(.DIM_WIDTH(DIM_WIDTH), .DIR_WIDTH(DIR_WIDTH)) u_scale_y (
        .i_clk(i_clk), .i_en(n_en), .i_radius(r_radius), .i_mag(r_ay),
        .i_norm(n_norm), .o_quot(n_qy)
    );
    cssp_scale #(.DIM_WIDTH(DIM_WIDTH), .DIR_WIDTH(DIR_WIDTH)) u_scale_z (
        .i_clk(i_clk), .i_en(n_en), .i_radius(r_radius), .i_mag(r_az),
        .i_norm(n_norm), .o_quot(n_qz)
    );

    logic  r_vd [0:LAT-1];
    t_side r_sd [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vd[k] <= 1'b0;
        end else if (n_en) begin
            r_vd[0] <= r_v1;
            for (int k = 1; k < LAT; k++) r_vd[k] <= r_vd[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sd[0] <= r_sb1;
            for (int k = 1; k < LAT; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // ---------------- result assembly ----------------
    t_side                n_sb;
    logic signed [EW-1:0] n_sx, n_sy, n_sz;
    logic signed [EW-1:0] n_qxs, n_qys, n_qzs, n_half;

    assign n_sb = r_sd[LAT-1];

    always_comb begin
        n_qxs  = n_sb.neg_x ? -EW'(n_qx) : EW'(n_qx);
        n_qys  = n_sb.neg_y ? -EW'(n_qy) : EW'(n_qy);
        n_qzs  = n_sb.neg_z ? -EW'(n_qz) : EW'(n_qz);
        n_half = EW'(r_axis >> 1);
        n_sx   = '0;
        n_sy   = '0;
        n_sz   = '0;
        case (r_kind)
            KIND_SPHERE, KIND_CAPSULE: begin
                if (n_sb.zero_xyz) begin
                    n_sx = EW'(r_radius);
                end else begin
                    n_sx = n_qxs;
                    n_sy = n_qys;
                    n_sz = n_qzs;
                    if (r_kind == KIND_CAPSULE) begin
                        n_sz = n_sb.pos_z ? (n_qzs + n_half) : (n_qzs - n_half);
                    end
                end
            end
            KIND_BOX: begin
                n_sx = n_sb.neg_x ? -EW'(r_box_x >> 1) : EW'(r_box_x >> 1);
                n_sy = n_sb.neg_y ? -EW'(r_box_y >> 1) : EW'(r_box_y >> 1);
                n_sz = n_sb.neg_z ? -EW'(r_box_z >> 1) : EW'(r_box_z >> 1);
            end
            default: begin
                if (!n_sb.zero_xy) begin
                    n_sx = n_qxs;
                    n_sy = n_qys;
                end
                if (n_sb.pos_z) n_sz = n_half;
                else if (n_sb.neg_z) n_sz = -n_half;
            end
        endcase
    end

    logic [OUT_W-1:0] r_ox, r_oy, r_oz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (n_en) begin
            r_ovalid <= r_vd[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ox <= n_sx[OUT_W-1:0];
            r_oy <= n_sy[OUT_W-1:0];
            r_oz <= n_sz[OUT_W-1:0];
        end
    end

    assign o_valid     = r_ovalid;
    assign o_support_x = r_ox;
    assign o_support_y = r_oy;
    assign o_support_z = r_oz;

endmodule

// ===== src/cssp_checker.sv =====
// ----------------------------------------------------------------------------
// cssp_port_props
// Port-level checks on the support point block's result channel.
// ----------------------------------------------------------------------------
module cssp_port_props
    import cssp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_stall,
    input logic [OUT_W-1:0] o_support_x,
    input logic [OUT_W-1:0] o_support_y,
    input logic [OUT_W-1:0] o_support_z
);

    // The input side only stalls when a finished result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without a blocked result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_support_x) && $stable(o_support_y)
            && $stable(o_support_z))
        else $error("stalled result changed");

endmodule

bind convex_shape_support_point cssp_port_props u_cssp_port_props (.*);

// ===== sim/cssp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssp_checker
// Watches the direction and support point channels and the register port,
// predicts each support point from the shape settings, and compares it.
// ----------------------------------------------------------------------------
module cssp_checker
    import cssp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic [15:0]       i_dir_x,
    input  logic [15:0]       i_dir_y,
    input  logic [15:0]       i_dir_z,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic [OUT_W-1:0]  o_support_x,
    input  logic [OUT_W-1:0]  o_support_y,
    input  logic [OUT_W-1:0]  o_support_z,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
    } t_point;

    t_kind       kind_q;
    logic [15:0] radius_q, length_q, box_x_q, box_y_q, box_z_q;
    t_point      expected_points [DEPTH];
    int          wr_count;
    int          rd_count;

    // Largest q with q*q*norm_sq <= r*r*a*a, searched bit by bit.
    function automatic longint scale_axis(longint r, longint d, longint norm_sq);
        longint            a;
        longint            q;
        longint            c;
        logic [127:0]      lhs;
        logic [127:0]      rhs;
        a   = (d < 0) ? -d : d;
        q   = 0;
        rhs = 128'(r * r) * 128'(a * a);
        for (int b = 15; b >= 0; b--) begin
            c = q | (longint'(1) << b);
            if (c <= r) begin
                lhs = 128'(c * c) * 128'(norm_sq);
                if (lhs <= rhs) q = c;
            end
        end
        return (d < 0) ? -q : q;
    endfunction

    function automatic t_point support_of(logic [15:0] ux, logic [15:0] uy,
                                          logic [15:0] uz);
        longint dx, dy, dz, sx, sy, sz, half, n3, n2;
        t_point p;
        dx   = longint'($signed(ux));
        dy   = longint'($signed(uy));
        dz   = longint'($signed(uz));
        sx   = 0;
        sy   = 0;
        sz   = 0;
        half = longint'(length_q >> 1);
        n2   = dx * dx + dy * dy;
        n3   = n2 + dz * dz;
        case (kind_q)
            KIND_SPHERE, KIND_CAPSULE: begin
                if (n3 == 0) begin
                    sx = longint'(radius_q);
                end else begin
                    sx = scale_axis(radius_q, dx, n3);
                    sy = scale_axis(radius_q, dy, n3);
                    sz = scale_axis(radius_q, dz, n3);
                    if (kind_q == KIND_CAPSULE) sz += (dz > 0) ? half : -half;
                end
            end
            KIND_BOX: begin
                sx = longint'(box_x_q >> 1);
                sy = longint'(box_y_q >> 1);
                sz = longint'(box_z_q >> 1);
                if (dx < 0) sx = -sx;
                if (dy < 0) sy = -sy;
                if (dz < 0) sz = -sz;
            end
            default: begin
                if (n2 != 0) begin
                    sx = scale_axis(radius_q, dx, n2);
                    sy = scale_axis(radius_q, dy, n2);
                end
                sz = (dz == 0) ? 0 : ((dz > 0) ? half : -half);
            end
        endcase
        p.x = sx[OUT_W-1:0];
        p.y = sy[OUT_W-1:0];
        p.z = sz[OUT_W-1:0];
        return p;
    endfunction

    assign o_pending = wr_count - rd_count;

    always @(posedge i_clk) begin
        t_point want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            kind_q   <= KIND_SPHERE;
            radius_q <= '0;
            length_q <= '0;
            box_x_q  <= '0;
            box_y_q  <= '0;
            box_z_q  <= '0;
            wr_count <= 0;
            rd_count <= 0;
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_SHAPE_KIND:  kind_q   <= t_kind'(pwdata[1:0]);
                    REG_RADIUS:      radius_q <= pwdata[15:0];
                    REG_AXIS_LENGTH: length_q <= pwdata[15:0];
                    REG_BOX_X:       box_x_q  <= pwdata[15:0];
                    REG_BOX_Y:       box_y_q  <= pwdata[15:0];
                    REG_BOX_Z:       box_z_q  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                expected_points[wr_count % DEPTH] <= support_of(i_dir_x, i_dir_y, i_dir_z);
                wr_count <= wr_count + 1;
            end
            if (o_valid && !i_stall) begin
                if (wr_count == rd_count) begin
                    $error("support point with no direction outstanding");
                    errs++;
                end else begin
                    want = expected_points[rd_count % DEPTH];
                    rd_count <= rd_count + 1;
                    if (want.x !== o_support_x) begin
                        $error("support_x expected %0h actual %0h", want.x, o_support_x);
                        errs++;
                    end
                    if (want.y !== o_support_y) begin
                        $error("support_y expected %0h actual %0h", want.y, o_support_y);
                        errs++;
                    end
                    if (want.z !== o_support_z) begin
                        $error("support_z expected %0h actual %0h", want.z, o_support_z);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ===== sim/tb_convex_shape_support_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_shape_support_point
// Drives direction queries through every shape setting, with bursty input
// and a stalling receiver; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_convex_shape_support_point;
    import cssp_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [15:0]       i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [OUT_W-1:0]  o_support_x, o_support_y, o_support_z;
    int                fail_count;
    int                pending;
    int                stall_mode;

    convex_shape_support_point dut (.*);

    cssp_checker checker_i (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_valid, .o_stall, .i_dir_x, .i_dir_y, .i_dir_z, .o_valid, .i_stall,
        .o_support_x, .o_support_y, .o_support_z,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("[convex_shape_support_point] ERROR");
        $finish;
    end

    // Receiver stall pattern: none, light random, heavy random, or periodic.
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (($time / 4) % 7) < 3;
        endcase
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_shape(t_kind kind, logic [15:0] r, logic [15:0] len,
                             logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
        write_reg(REG_SHAPE_KIND, 32'(kind));
        write_reg(REG_RADIUS, 32'(r));
        write_reg(REG_AXIS_LENGTH, 32'(len));
        write_reg(REG_BOX_X, 32'(bx));
        write_reg(REG_BOX_Y, 32'(by));
        write_reg(REG_BOX_Z, 32'(bz));
    endtask

    // Presents one direction and holds it until the block takes it.
    task automatic send_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        i_valid <= 1'b1;
        i_dir_x <= x;
        i_dir_y <= y;
        i_dir_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_component();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'($signed($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_burst_run(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_dir(rand_component(), rand_component(), rand_component());
                sent++;
            end
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] edge_vals [6];
        stall_mode = 0;
        edge_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every shape at extreme sizes, zero and extreme directions.
        for (int kind = 0; kind < 4; kind++) begin
            set_shape(t_kind'(kind), 16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'hfffe);
            stall_mode = kind;
            send_dir(16'h0000, 16'h0000, 16'h0000);
            send_dir(16'h0000, 16'h0000, 16'h8000);
            send_dir(16'h8000, 16'h7fff, 16'h0000);
            send_dir(16'h7fff, 16'h7fff, 16'h7fff);
            send_dir(16'h8000, 16'h8000, 16'h8000);
            send_dir(edge_vals[$urandom_range(0, 5)], 16'h0000, 16'h0001);
            i_valid <= 1'b0;
            drain();
        end

        // Random phases over many settings, starting with zero sizes for every shape.
        for (int phase = 0; phase < 14; phase++) begin
            stall_mode = phase % 4;
            if (phase < 4)
                set_shape(t_kind'(phase), 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            else
                set_shape(t_kind'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
            random_burst_run(120);
            drain();
        end

        if (fail_count == 0) begin
            $display("[convex_shape_support_point] OK");
        end else begin
            $display("[convex_shape_support_point] ERROR");
        end
        $finish;
    end

endmodule

// ===== convex_shape_support_point.f =====
src/cssp_pkg.sv
src/cssp_scale.sv
src/convex_shape_support_point.sv
src/cssp_checker.sv
sim/cssp_checker.sv
sim/tb_convex_shape_support_point.sv
